[hdl/sab_pkg.sv]
// Shared constants and types of the suffix array builder.
package sab_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int AW        = $clog2(MAX_LEN);
    localparam int LW        = AW + 1;
    localparam int SYM_W     = 7;
    localparam int CNT_W     = LW;
    localparam int CHAR_BINS = 1 << SYM_W;

    localparam logic [SYM_W-1:0] SENTINEL = SYM_W'(32);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_READ  = 1'b1;
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Write and read requests from the sequencer to the stores.
    typedef struct packed {
        logic              text_we;
        logic [AW-1:0]     text_wa;
        logic [SYM_W-1:0]  text_wd;
        logic [AW-1:0]     text_ra;
        logic              ord_we;
        logic [AW-1:0]     ord_wa;
        logic [AW-1:0]     ord_wd;
        logic [AW-1:0]     ord_ra;
        logic              cls_we;
        logic [AW-1:0]     cls_wa;
        logic [AW-1:0]     cls_wd;
        logic [AW-1:0]     cls_ra_a;
        logic [AW-1:0]     cls_ra_b;
        logic              aux_we;
        logic [AW-1:0]     aux_wa;
        logic [AW-1:0]     aux_wd;
        logic [AW-1:0]     aux_ra;
        logic              cnt_we;
        logic [AW-1:0]     cnt_wa;
        logic [CNT_W-1:0]  cnt_wd;
        logic [AW-1:0]     cnt_ra;
    } sab_mem_req_t;

    // Registered read data returned by the stores.
    typedef struct packed {
        logic [SYM_W-1:0]  text;
        logic [AW-1:0]     ord;
        logic [AW-1:0]     cls_a;
        logic [AW-1:0]     cls_b;
        logic [AW-1:0]     aux;
        logic [CNT_W-1:0]  cnt;
    } sab_mem_rsp_t;

endpackage

[hdl/sab_ram.sv]
// Generic synchronous RAM, one write port and one registered read port.
module sab_ram #(
    parameter int DW = 8,
    parameter int AW = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [DW-1:0] wd,
    input  logic [AW-1:0] ra,
    output logic [DW-1:0] rd
);

    logic [DW-1:0] mem [1 << AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

[hdl/sab_seq.sv]
// Build and query sequencer: sweeps the stores one element at a time.
module sab_seq
    import sab_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [SYM_W-1:0]  symbol,
    input  logic              last,
    input  logic [AW-1:0]     rank_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [AW-1:0]     suffix_start,
    output logic [AW-1:0]     class_id,
    output logic [LW-1:0]     text_length,
    output logic [1:0]        status,
    output sab_mem_req_t      mreq,
    input  sab_mem_rsp_t      mrsp
);

    typedef enum logic [5:0] {
        S_IDLE, S_SENT, S_CLRC,
        S_H0, S_H1, S_H2,
        S_P0, S_P1,
        S_L0, S_L1, S_L2,
        S_F0, S_F1, S_F2,
        S_CHK,
        S_R0, S_R1,
        S_CB,
        S_C0, S_C1, S_C2,
        S_PR0, S_PR1,
        S_S0, S_S1, S_S2, S_S3,
        S_K0, S_K1,
        S_Q0, S_Q1, S_Q2,
        S_J0, S_J1,
        S_RD0, S_RD1
    } state_t;

    state_t            state_reg;
    logic [LW-1:0]     i_reg;
    logic [LW-1:0]     n_reg;
    logic [LW-1:0]     acc_reg;
    logic [LW-1:0]     shift_reg;
    logic [AW-1:0]     x_reg;
    logic [AW-1:0]     key_reg;
    logic [AW-1:0]     prev_reg;
    logic [AW-1:0]     pa_reg;
    logic [AW-1:0]     pb_reg;
    logic [SYM_W-1:0]  pt_reg;
    logic [3:0]        step_reg;
    logic              built_reg;
    logic              ovf_reg;
    logic              ovalid_reg;
    logic              okind_reg;
    logic [AW-1:0]     ostart_reg;
    logic [AW-1:0]     ocls_reg;
    logic [LW-1:0]     olen_reg;
    logic [1:0]        ostat_reg;

    logic              accept;
    logic [LW-1:0]     cnt0;
    logic              room;
    logic [LW-1:0]     cnt1;
    logic              last_i;
    logic              last_bin;
    logic [LW:0]       back_sum;
    logic [AW-1:0]     back_pos;
    logic [LW:0]       fwd_sum;
    logic [AW-1:0]     fwd_pos;
    logic [AW-1:0]     first_cls;
    logic [AW-1:0]     round_cls;
    logic [LW:0]       span;
    logic              go_round;

    assign in_ready     = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept       = in_valid && in_ready;
    assign out_valid    = ovalid_reg;
    assign kind         = okind_reg;
    assign suffix_start = ostart_reg;
    assign class_id     = ocls_reg;
    assign text_length  = olen_reg;
    assign status       = ostat_reg;

    assign cnt0     = built_reg ? '0 : n_reg;
    assign room     = cnt0 < LW'(MAX_LEN - 1);
    assign cnt1     = room ? cnt0 + LW'(1) : cnt0;
    assign last_i   = (i_reg + LW'(1)) == n_reg;
    assign last_bin = i_reg == LW'(CHAR_BINS - 1);

    // Cyclic shift of a position back and forward by the current span (1 << step).
    always_comb begin
        if ({1'b0, mrsp.ord} >= shift_reg) begin
            back_sum = {1'b0, LW'(mrsp.ord) - shift_reg};
        end else begin
            back_sum = {1'b0, LW'(mrsp.ord)} + {1'b0, n_reg} - {1'b0, shift_reg};
        end
        back_pos = back_sum[AW-1:0];
        fwd_sum  = {1'b0, LW'(mrsp.ord)} + {1'b0, shift_reg};
        if (fwd_sum >= {1'b0, n_reg}) begin
            fwd_sum = fwd_sum - {1'b0, n_reg};
        end
        fwd_pos = fwd_sum[AW-1:0];
    end

    assign first_cls = (i_reg == '0) ? '0
                     : prev_reg + AW'(mrsp.text != pt_reg);
    assign round_cls = (i_reg == '0) ? '0
                     : prev_reg + AW'((mrsp.cls_a != pa_reg) || (mrsp.cls_b != pb_reg));
    assign span      = (LW + 1)'(1) << step_reg;
    assign go_round  = (span < {1'b0, n_reg}) && (LW'(prev_reg) < n_reg - LW'(1));

    always_comb begin
        mreq = '0;
        unique case (state_reg)
            S_IDLE: begin
                mreq.text_we = accept && (req_type == REQ_LOAD) && room;
                mreq.text_wa = cnt0[AW-1:0];
                mreq.text_wd = symbol;
                mreq.ord_ra  = rank_index;
            end
            S_SENT: begin
                mreq.text_we = 1'b1;
                mreq.text_wa = n_reg[AW-1:0];
                mreq.text_wd = SENTINEL;
            end
            S_CLRC, S_CB: begin
                mreq.cnt_we = 1'b1;
                mreq.cnt_wa = i_reg[AW-1:0];
            end
            S_H0, S_L0: mreq.text_ra = i_reg[AW-1:0];
            S_H1, S_L1: mreq.cnt_ra = AW'(mrsp.text);
            S_H2, S_C2: begin
                mreq.cnt_we = 1'b1;
                mreq.cnt_wa = key_reg;
                mreq.cnt_wd = mrsp.cnt + CNT_W'(1);
            end
            S_P0, S_PR0: mreq.cnt_ra = i_reg[AW-1:0];
            S_P1, S_PR1: begin
                mreq.cnt_we = 1'b1;
                mreq.cnt_wa = i_reg[AW-1:0];
                mreq.cnt_wd = acc_reg;
            end
            S_L2: begin
                mreq.ord_we = 1'b1;
                mreq.ord_wa = mrsp.cnt[AW-1:0];
                mreq.ord_wd = i_reg[AW-1:0];
                mreq.cnt_we = 1'b1;
                mreq.cnt_wa = key_reg;
                mreq.cnt_wd = mrsp.cnt + CNT_W'(1);
            end
            S_F0, S_R0, S_S0, S_Q0: mreq.ord_ra = i_reg[AW-1:0];
            S_F1: mreq.text_ra = mrsp.ord;
            S_F2: begin
                mreq.cls_we = 1'b1;
                mreq.cls_wa = x_reg;
                mreq.cls_wd = first_cls;
            end
            S_CHK: ;
            S_R1: begin
                mreq.ord_we = 1'b1;
                mreq.ord_wa = i_reg[AW-1:0];
                mreq.ord_wd = back_pos;
            end
            S_C0: mreq.cls_ra_a = i_reg[AW-1:0];
            S_C1, S_S2: mreq.cnt_ra = mrsp.cls_a;
            S_S1, S_RD0: mreq.cls_ra_a = mrsp.ord;
            S_S3: begin
                mreq.aux_we = 1'b1;
                mreq.aux_wa = mrsp.cnt[AW-1:0];
                mreq.aux_wd = x_reg;
                mreq.cnt_we = 1'b1;
                mreq.cnt_wa = key_reg;
                mreq.cnt_wd = mrsp.cnt + CNT_W'(1);
            end
            S_K0, S_J0: mreq.aux_ra = i_reg[AW-1:0];
            S_K1: begin
                mreq.ord_we = 1'b1;
                mreq.ord_wa = i_reg[AW-1:0];
                mreq.ord_wd = mrsp.aux;
            end
            S_Q1: begin
                mreq.cls_ra_a = mrsp.ord;
                mreq.cls_ra_b = fwd_pos;
            end
            S_Q2: begin
                mreq.aux_we = 1'b1;
                mreq.aux_wa = x_reg;
                mreq.aux_wd = round_cls;
            end
            S_J1: begin
                mreq.cls_we = 1'b1;
                mreq.cls_wa = i_reg[AW-1:0];
                mreq.cls_wd = mrsp.aux;
            end
            S_RD1: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            step_reg   <= '0;
            built_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            i_reg      <= '0;
        end else begin
            if (ovalid_reg && out_ready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept && (req_type == REQ_LOAD)) begin
                        built_reg <= 1'b0;
                        n_reg     <= cnt1;
                        ovf_reg   <= (built_reg ? 1'b0 : ovf_reg) || !room;
                        if (last) begin
                            state_reg <= S_SENT;
                        end
                    end else if (accept) begin
                        if (!built_reg || LW'(rank_index) >= n_reg) begin
                            ovalid_reg <= 1'b1;
                            okind_reg  <= KIND_READ;
                            ostart_reg <= '0;
                            ocls_reg   <= '0;
                            olen_reg   <= built_reg ? n_reg : '0;
                            ostat_reg  <= ST_RANGE;
                        end else begin
                            state_reg <= S_RD0;
                        end
                    end
                end
                S_SENT: begin
                    n_reg     <= n_reg + LW'(1);
                    step_reg  <= '0;
                    i_reg     <= '0;
                    state_reg <= S_CLRC;
                end
                S_CLRC: begin
                    i_reg <= i_reg + LW'(1);
                    if (last_bin) begin
                        i_reg     <= '0;
                        state_reg <= S_H0;
                    end
                end
                S_H0: state_reg <= S_H1;
                S_H1: begin
                    key_reg   <= AW'(mrsp.text);
                    state_reg <= S_H2;
                end
                S_H2: begin
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_H0;
                    if (last_i) begin
                        i_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_P0;
                    end
                end
                S_P0: state_reg <= S_P1;
                S_P1: begin
                    acc_reg   <= acc_reg + mrsp.cnt;
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_P0;
                    if (last_bin) begin
                        i_reg     <= '0;
                        state_reg <= S_L0;
                    end
                end
                S_L0: state_reg <= S_L1;
                S_L1: begin
                    key_reg   <= AW'(mrsp.text);
                    state_reg <= S_L2;
                end
                S_L2: begin
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_L0;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_F0;
                    end
                end
                S_F0: state_reg <= S_F1;
                S_F1: begin
                    x_reg     <= mrsp.ord;
                    state_reg <= S_F2;
                end
                S_F2: begin
                    prev_reg  <= first_cls;
                    pt_reg    <= mrsp.text;
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_F0;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (go_round) begin
                        shift_reg <= span[LW-1:0];
                        state_reg <= S_R0;
                    end else begin
                        built_reg  <= 1'b1;
                        ovalid_reg <= 1'b1;
                        okind_reg  <= KIND_DONE;
                        ostart_reg <= '0;
                        ocls_reg   <= '0;
                        olen_reg   <= n_reg;
                        ostat_reg  <= ovf_reg ? ST_OVF : ST_OK;
                        state_reg  <= S_IDLE;
                    end
                end
                S_R0: state_reg <= S_R1;
                S_R1: begin
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_R0;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_CB;
                    end
                end
                S_CB: begin
                    i_reg <= i_reg + LW'(1);
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_C0;
                    end
                end
                S_C0: state_reg <= S_C1;
                S_C1: begin
                    key_reg   <= mrsp.cls_a;
                    state_reg <= S_C2;
                end
                S_C2: begin
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_C0;
                    if (last_i) begin
                        i_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_PR0;
                    end
                end
                S_PR0: state_reg <= S_PR1;
                S_PR1: begin
                    acc_reg   <= acc_reg + mrsp.cnt;
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_PR0;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_S0;
                    end
                end
                S_S0: state_reg <= S_S1;
                S_S1: begin
                    x_reg     <= mrsp.ord;
                    state_reg <= S_S2;
                end
                S_S2: begin
                    key_reg   <= mrsp.cls_a;
                    state_reg <= S_S3;
                end
                S_S3: begin
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_S0;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_K0;
                    end
                end
                S_K0: state_reg <= S_K1;
                S_K1: begin
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_K0;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_Q0;
                    end
                end
                S_Q0: state_reg <= S_Q1;
                S_Q1: begin
                    x_reg     <= mrsp.ord;
                    state_reg <= S_Q2;
                end
                S_Q2: begin
                    prev_reg  <= round_cls;
                    pa_reg    <= mrsp.cls_a;
                    pb_reg    <= mrsp.cls_b;
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_Q0;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= S_J0;
                    end
                end
                S_J0: state_reg <= S_J1;
                S_J1: begin
                    i_reg     <= i_reg + LW'(1);
                    state_reg <= S_J0;
                    if (last_i) begin
                        i_reg     <= '0;
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_CHK;
                    end
                end
                S_RD0: begin
                    x_reg     <= mrsp.ord;
                    state_reg <= S_RD1;
                end
                S_RD1: begin
                    ovalid_reg <= 1'b1;
                    okind_reg  <= KIND_READ;
                    ostart_reg <= x_reg;
                    ocls_reg   <= mrsp.cls_a;
                    olen_reg   <= n_reg;
                    ostat_reg  <= ST_OK;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/suffix_array_builder_unit.sv]
// Top level of the suffix array builder: stores and build sequencer.
//
// Usage: requests enter on the s_ channel. A load request (s_tuser = 0)
// appends one character; the request with s_tlast set also appends the
// sentinel and starts the build, which ends with one done report on the m_
// channel (m_tuser = 0) carrying the text length and overflow status. A read
// request (s_tuser = 1) returns one answer (m_tuser = 1) with the suffix start
// and its final class at the requested rank.
// Build: with n the text length including the sentinel, the build runs a
// character sort and then at most ceil(log2(n)) doubling rounds, ending early
// once every class is distinct; every sweep moves one element through a
// single-port read of each store per step, so the store read latency sets the
// cost. A read out of range is answered from the idle state without reading
// the stores.
// Reset clears the control state; the stores are left as they are and hold
// nothing readable until a build has run. The block takes one request at a time:
// s_tready stays low during a build and while a result waits for m_tready, so a
// stalled receiver simply holds the block.
module suffix_array_builder_unit
    import sab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // symbol[6:0], rank_index[16:7], zero fill
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // suffix_start[9:0], class_id[19:10],
                                   // text_length[30:20], status[32:31], zero fill
    output logic        m_tuser    // kind
);

    sab_mem_req_t     mreq;
    sab_mem_rsp_t     mrsp;
    logic [AW-1:0]    suffix_start;
    logic [AW-1:0]    class_id;
    logic [LW-1:0]    text_length;
    logic [1:0]       status;

    // The sequencer owns all control; the stores below only hold data.
    sab_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tuser),
        .symbol       (s_tdata[SYM_W-1:0]),
        .last         (s_tlast),
        .rank_index   (s_tdata[SYM_W+AW-1:SYM_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .kind         (m_tuser),
        .suffix_start (suffix_start),
        .class_id     (class_id),
        .text_length  (text_length),
        .status       (status),
        .mreq         (mreq),
        .mrsp         (mrsp)
    );

    assign m_tdata = {7'd0, status, text_length, class_id, suffix_start};

    // Text characters.
    sab_ram #(.DW(SYM_W), .AW(AW)) u_text (
        .aclk (aclk), .we (mreq.text_we), .wa (mreq.text_wa), .wd (mreq.text_wd),
        .ra (mreq.text_ra), .rd (mrsp.text)
    );

    // Suffix order.
    sab_ram #(.DW(AW), .AW(AW)) u_order (
        .aclk (aclk), .we (mreq.ord_we), .wa (mreq.ord_wa), .wd (mreq.ord_wd),
        .ra (mreq.ord_ra), .rd (mrsp.ord)
    );

    // Class store, kept as two identical copies so a pair can be read at once.
    sab_ram #(.DW(AW), .AW(AW)) u_class_a (
        .aclk (aclk), .we (mreq.cls_we), .wa (mreq.cls_wa), .wd (mreq.cls_wd),
        .ra (mreq.cls_ra_a), .rd (mrsp.cls_a)
    );

    sab_ram #(.DW(AW), .AW(AW)) u_class_b (
        .aclk (aclk), .we (mreq.cls_we), .wa (mreq.cls_wa), .wd (mreq.cls_wd),
        .ra (mreq.cls_ra_b), .rd (mrsp.cls_b)
    );

    // Scratch store: scattered order, then the next classes of a round.
    sab_ram #(.DW(AW), .AW(AW)) u_aux (
        .aclk (aclk), .we (mreq.aux_we), .wa (mreq.aux_wa), .wd (mreq.aux_wd),
        .ra (mreq.aux_ra), .rd (mrsp.aux)
    );

    // Bucket counts for the character sort and the class sort.
    sab_ram #(.DW(CNT_W), .AW(AW)) u_count (
        .aclk (aclk), .we (mreq.cnt_we), .wa (mreq.cnt_wa), .wd (mreq.cnt_wd),
        .ra (mreq.cnt_ra), .rd (mrsp.cnt)
    );

endmodule
